// File: src/hwrg_pkg.sv
// Shared types and constants for the H-bridge wheel reversal guard.
`timescale 1ns / 1ps

package hwrg_pkg;

  // Command codes on the input channel
  localparam logic [1:0] CMD_SET  = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_STOP = 2'd2;

  // Direction codes kept per wheel
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_POS  = 2'd1;
  localparam logic [1:0] DIR_NEG  = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_TICKS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_DUTY  = 2'd3;
  localparam int CFG_DATA_W = 16;

  // Field widths
  localparam int SPEED_W = 16;
  localparam int MAX_W   = 15;
  localparam int BAND_W  = 10;
  localparam int PAUSE_W = 16;
  localparam int DUTY_W  = 8;

  // Register reset values
  localparam logic [MAX_W-1:0]   MAX_SPEED_RST   = 15'd12288;
  localparam logic [BAND_W-1:0]  DEAD_BAND_RST   = 10'd10;
  localparam logic [PAUSE_W-1:0] PAUSE_TICKS_RST = 16'd150;
  localparam logic [DUTY_W-1:0]  FIXED_DUTY_RST  = 8'd0;

  // One wheel's state word as held in the state memory
  typedef struct packed {
    logic signed [SPEED_W-1:0] wanted;
    logic [1:0]                dir;
    logic [PAUSE_W-1:0]        pause_left;
    logic                      paused;
    logic [DUTY_W-1:0]         duty;
    logic                      pin_a;
    logic                      pin_b;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: src/hwrg_in_if.sv
// Input channel: command, wheel and speed with valid/ready.
`timescale 1ns / 1ps

interface hwrg_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic [1:0]               wheel;
  logic signed [hwrg_pkg::SPEED_W-1:0] speed;

  modport source (output valid, output cmd, output wheel, output speed, input ready);
  modport sink (input valid, input cmd, input wheel, input speed, output ready);
endinterface

// File: src/hwrg_out_if.sv
// Result channel: one wheel's pins, duty and change flag with valid/ready.
`timescale 1ns / 1ps

interface hwrg_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  wheel_id;
  logic [hwrg_pkg::DUTY_W-1:0] duty;
  logic                        pin_a;
  logic                        pin_b;
  logic                        changed;
  logic                        last;

  modport source (output valid, output wheel_id, output duty, output pin_a,
                  output pin_b, output changed, output last, input ready);
  modport sink (input valid, input wheel_id, input duty, input pin_a,
                input pin_b, input changed, input last, output ready);
endinterface

// File: src/hwrg_cfg_if.sv
// Configuration write channel: register index and data with valid/ready.
`timescale 1ns / 1ps

interface hwrg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hwrg_pkg::CFG_IDX_W-1:0]  index;
  logic [hwrg_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/hwrg_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hwrg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/hwrg_div.sv
// Serial duty divider: floor(mag * 255 / den), saturated at 255, one bit a cycle.
`timescale 1ns / 1ps

module hwrg_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [hwrg_pkg::SPEED_W-1:0]   mag,
  input  logic [hwrg_pkg::MAX_W-1:0]     den,
  output logic                           busy,
  output logic                           done,
  output logic [hwrg_pkg::DUTY_W-1:0]    quot
);

  localparam int NUM_W = hwrg_pkg::SPEED_W + hwrg_pkg::DUTY_W;
  localparam int DEN_W = hwrg_pkg::MAX_W + hwrg_pkg::DUTY_W;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] dsh_r, dsh_nxt;
  logic [hwrg_pkg::DUTY_W-1:0] q_r, q_nxt;
  logic             ge;

  assign ge = rem_r >= {1'b0, dsh_r};

  // Saturation check first, then one restoring step per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 4'd8;
      rem_nxt  = {mag, 8'd0} - NUM_W'(mag);
      dsh_nxt  = {den, 8'd0};
      q_nxt    = '0;
    end else if (busy_r) begin
      dsh_nxt = dsh_r >> 1;
      if (cnt_r == 4'd8) begin
        if (ge) begin
          q_nxt    = '1;
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          cnt_nxt = 4'd7;
        end
      end else begin
        if (ge) begin
          rem_nxt = rem_r - NUM_W'(dsh_r);
          q_nxt[cnt_r[2:0]] = 1'b1;
        end
        if (cnt_r == 4'd0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r - 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;

endmodule

// File: src/hbridge_wheel_reversal_guard.sv
// Top level: wheel state memory, control sequencer, duty divider and result register.
// Sequence: a set is accepted, its wheel read, then modified and written back. A tick or stop
// runs the wheels in turn (read, modify, emit), a tick adding a divider pass for
// a wheel with a scaled duty (nonzero speed, fixed duty zero).
// One item at a time; output stalls hold a tick or stop in its emit step.
// Reset: synchronous active low; registers take their reset values and per-wheel valid
// bits clear at once, so every wheel reads as all zero until written. No clearing pass.
`timescale 1ns / 1ps

module hbridge_wheel_reversal_guard #(
  parameter int WHEELS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  hwrg_in_if.sink     in_ch,
  hwrg_out_if.source  out_ch,
  hwrg_cfg_if.sink    cfg_ch
);

  localparam int WIDX_W = (WHEELS > 1) ? $clog2(WHEELS) : 1;
  localparam logic [WIDX_W-1:0] LAST_W = WIDX_W'(WHEELS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  // Configuration registers
  logic [hwrg_pkg::MAX_W-1:0]   max_speed_r;
  logic [hwrg_pkg::BAND_W-1:0]  dead_band_r;
  logic [hwrg_pkg::PAUSE_W-1:0] pause_ticks_r;
  logic [hwrg_pkg::DUTY_W-1:0]  fixed_duty_r;
  logic [hwrg_pkg::MAX_W-1:0]   eff_max;

  // Sequencer state
  logic [2:0]        state_r, state_nxt;
  logic [WIDX_W-1:0] w_r, w_nxt;
  logic [1:0]        cmd_r, cmd_nxt;
  logic signed [hwrg_pkg::SPEED_W-1:0] speed_r, speed_nxt;
  hwrg_pkg::entry_t  wk_r, wk_nxt;
  logic              hold_r, hold_nxt;
  logic [WHEELS-1:0] valid_r;
  logic              rd_vld_r;

  // Result register
  logic              out_valid_r;
  logic [1:0]        out_wheel_r;
  logic [hwrg_pkg::DUTY_W-1:0] out_duty_r;
  logic              out_a_r, out_b_r, out_chg_r, out_last_r;
  logic              out_free, out_load;

  // Memory port
  logic                        ram_we;
  logic [hwrg_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
  hwrg_pkg::entry_t            ent;
  hwrg_pkg::entry_t            wr_ent;

  // Divider
  logic                        div_start, div_busy, div_done;
  logic [hwrg_pkg::DUTY_W-1:0] div_q;
  logic [hwrg_pkg::SPEED_W-1:0] wk_mag;

  // Set-command clamp
  logic [hwrg_pkg::SPEED_W:0]  set_mag;
  logic signed [hwrg_pkg::SPEED_W-1:0] set_v;

  // Tick control-pass terms
  logic w_pos, w_neg, same, opp, still, hold_c;
  logic [hwrg_pkg::PAUSE_W-1:0] pl_dec;
  logic [1:0] dir1;
  logic [hwrg_pkg::PAUSE_W-1:0] pl1;
  logic signed [hwrg_pkg::SPEED_W-1:0] v_c;
  hwrg_pkg::entry_t tick_ent, stop_ent;

  // Emit terms
  logic [hwrg_pkg::DUTY_W-1:0] new_d;
  logic new_a, new_b, chg;

  assign eff_max = (max_speed_r == '0) ? hwrg_pkg::MAX_W'(1) : max_speed_r;

  // Configuration writes
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r   <= hwrg_pkg::MAX_SPEED_RST;
      dead_band_r   <= hwrg_pkg::DEAD_BAND_RST;
      pause_ticks_r <= hwrg_pkg::PAUSE_TICKS_RST;
      fixed_duty_r  <= hwrg_pkg::FIXED_DUTY_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        hwrg_pkg::CFG_MAX_SPEED:   max_speed_r   <= cfg_ch.data[hwrg_pkg::MAX_W-1:0];
        hwrg_pkg::CFG_DEAD_BAND:   dead_band_r   <= cfg_ch.data[hwrg_pkg::BAND_W-1:0];
        hwrg_pkg::CFG_PAUSE_TICKS: pause_ticks_r <= cfg_ch.data[hwrg_pkg::PAUSE_W-1:0];
        hwrg_pkg::CFG_FIXED_DUTY:  fixed_duty_r  <= cfg_ch.data[hwrg_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Wheel state memory
  hwrg_ram #(
    .WIDTH (hwrg_pkg::ENTRY_W),
    .DEPTH (WHEELS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (w_r),
    .wdata (ram_wdata),
    .raddr (w_r),
    .rdata (ram_rdata)
  );

  assign ram_wdata = wr_ent;
  // Never-written wheels read as zero
  assign ent = rd_vld_r ? hwrg_pkg::entry_t'(ram_rdata) : '0;

  // Duty divider
  assign wk_mag = wk_nxt.wanted[hwrg_pkg::SPEED_W-1] ?
                  hwrg_pkg::SPEED_W'(-wk_nxt.wanted) : wk_nxt.wanted;

  hwrg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .mag   (wk_mag),
    .den   (eff_max),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_q)
  );

  // Set command: dead band, then symmetric clamp to the effective maximum
  always_comb begin
    set_mag = speed_r[hwrg_pkg::SPEED_W-1] ?
              (hwrg_pkg::SPEED_W+1)'(-$signed({speed_r[hwrg_pkg::SPEED_W-1], speed_r})) :
              {1'b0, speed_r};
    if (set_mag < (hwrg_pkg::SPEED_W+1)'(dead_band_r)) begin
      set_v = '0;
    end else if (set_mag > (hwrg_pkg::SPEED_W+1)'(eff_max)) begin
      set_v = speed_r[hwrg_pkg::SPEED_W-1] ?
              hwrg_pkg::SPEED_W'(-$signed({1'b0, eff_max})) :
              $signed({1'b0, eff_max});
    end else begin
      set_v = speed_r;
    end
  end

  // Tick: pause countdown, reversal zeroing and direction update
  always_comb begin
    w_neg  = ent.wanted[hwrg_pkg::SPEED_W-1];
    w_pos  = !w_neg && (ent.wanted != '0);
    same   = ((ent.dir == hwrg_pkg::DIR_POS) && w_pos) ||
             ((ent.dir == hwrg_pkg::DIR_NEG) && w_neg);
    opp    = ((ent.dir == hwrg_pkg::DIR_POS) && w_neg) ||
             ((ent.dir == hwrg_pkg::DIR_NEG) && w_pos);
    still  = ent.paused && !same;
    pl_dec = (ent.pause_left != '0) ? ent.pause_left - 1'b1 : '0;
    hold_c = still && (pl_dec != '0);
    dir1   = (still && (pl_dec == '0)) ? hwrg_pkg::DIR_NONE : ent.dir;
    pl1    = still ? pl_dec : ent.pause_left;
    v_c    = (opp && !ent.paused) ? '0 : ent.wanted;

    tick_ent = ent;
    if (hold_c) begin
      tick_ent.pause_left = pl_dec;
    end else begin
      tick_ent.wanted     = v_c;
      tick_ent.dir        = dir1;
      tick_ent.pause_left = pl1;
      tick_ent.paused     = still;
      if (v_c != '0) begin
        tick_ent.dir = v_c[hwrg_pkg::SPEED_W-1] ? hwrg_pkg::DIR_NEG : hwrg_pkg::DIR_POS;
      end else if (dir1 != hwrg_pkg::DIR_NONE) begin
        tick_ent.pause_left = pause_ticks_r;
        tick_ent.paused     = 1'b1;
      end
    end

    stop_ent        = ent;
    stop_ent.wanted = '0;
    stop_ent.dir    = hwrg_pkg::DIR_NONE;
  end

  // Emit: new outputs from the stored speed, change against held outputs
  always_comb begin
    if (hold_r) begin
      new_d = wk_r.duty;
      new_a = wk_r.pin_a;
      new_b = wk_r.pin_b;
    end else begin
      new_a = wk_r.wanted[hwrg_pkg::SPEED_W-1];
      new_b = !wk_r.wanted[hwrg_pkg::SPEED_W-1] && (wk_r.wanted != '0);
      if (wk_r.wanted == '0) begin
        new_d = '0;
      end else if (fixed_duty_r != '0) begin
        new_d = fixed_duty_r;
      end else begin
        new_d = div_q;
      end
    end
    chg = (new_d != wk_r.duty) || (new_a != wk_r.pin_a) || (new_b != wk_r.pin_b);
  end

  assign out_free = !out_valid_r || out_ch.ready;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    w_nxt     = w_r;
    cmd_nxt   = cmd_r;
    speed_nxt = speed_r;
    wk_nxt    = wk_r;
    hold_nxt  = hold_r;
    ram_we    = 1'b0;
    wr_ent    = wk_r;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = in_ch.cmd;
          speed_nxt = in_ch.speed;
          w_nxt     = '0;
          case (in_ch.cmd)
            hwrg_pkg::CMD_SET: begin
              w_nxt = WIDX_W'(in_ch.wheel);
              if (32'(in_ch.wheel) < WHEELS) begin
                state_nxt = S_RD;
              end
            end
            hwrg_pkg::CMD_TICK, hwrg_pkg::CMD_STOP: state_nxt = S_RD;
            default: ;
          endcase
        end
      end
      S_RD: state_nxt = S_CALC;
      S_CALC: begin
        hold_nxt = 1'b0;
        case (cmd_r)
          hwrg_pkg::CMD_SET: begin
            wr_ent        = ent;
            wr_ent.wanted = set_v;
            ram_we        = 1'b1;
            state_nxt     = S_IDLE;
          end
          hwrg_pkg::CMD_STOP: begin
            wk_nxt    = stop_ent;
            state_nxt = S_EMIT;
          end
          hwrg_pkg::CMD_TICK: begin
            wk_nxt   = tick_ent;
            hold_nxt = hold_c;
            if (!hold_c && (fixed_duty_r == '0) && (tick_ent.wanted != '0)) begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end else begin
              state_nxt = S_EMIT;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          wr_ent       = wk_r;
          wr_ent.duty  = new_d;
          wr_ent.pin_a = new_a;
          wr_ent.pin_b = new_b;
          ram_we       = 1'b1;
          out_load     = 1'b1;
          if (w_r == LAST_W) begin
            state_nxt = S_IDLE;
          end else begin
            w_nxt     = w_r + WIDX_W'(1);
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      w_r         <= '0;
      cmd_r       <= hwrg_pkg::CMD_SET;
      hold_r      <= 1'b0;
      valid_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      w_r      <= w_nxt;
      cmd_r    <= cmd_nxt;
      hold_r   <= hold_nxt;
      rd_vld_r <= valid_r[w_r];
      if (ram_we) begin
        valid_r[w_r] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    speed_r <= speed_nxt;
    wk_r    <= wk_nxt;
    if (out_load) begin
      out_wheel_r <= 2'(w_r);
      out_duty_r  <= new_d;
      out_a_r     <= new_a;
      out_b_r     <= new_b;
      out_chg_r   <= chg;
      out_last_r  <= (w_r == LAST_W);
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.wheel_id = out_wheel_r;
  assign out_ch.duty     = out_duty_r;
  assign out_ch.pin_a    = out_a_r;
  assign out_ch.pin_b    = out_b_r;
  assign out_ch.changed  = out_chg_r;
  assign out_ch.last     = out_last_r;

  // The divider only runs while the sequencer waits on it
  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == S_DIV))
    else $error("divider busy outside divide state");

  // Memory writes happen only in the modify or emit steps
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == S_CALC) || (state_r == S_EMIT)))
    else $error("state memory written outside modify/emit");

  // Emitting the final wheel returns to idle with a last result pending
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (w_r == LAST_W)) |=> ((state_r == S_IDLE) && out_valid_r && out_last_r))
    else $error("final wheel result not followed by idle");

  // A held pass never reports a change
  a_hold_nochg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && hold_r) |=> !out_chg_r)
    else $error("held pass flagged as changed");

endmodule

// File: tb/sv/hbridge_wheel_reversal_guard_tb.sv
// Self-checking bench for the H-bridge wheel reversal guard: directed rows, then random phases.
`timescale 1ns / 1ps

module hbridge_wheel_reversal_guard_tb;
  import hwrg_pkg::*;

  localparam int WHEELS          = 4;
  localparam int NDIR            = 19;
  localparam int NPHASE          = 8;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int SETTLE          = 64;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // One wheel's report as seen on the result channel
  typedef struct packed {
    logic [1:0]        wheel_id;
    logic [DUTY_W-1:0] duty;
    logic              pin_a;
    logic              pin_b;
    logic              changed;
    logic              last;
  } wheel_report_t;

  // Command row; when exp_given is set the per-wheel outputs are fixed by the row
  typedef struct packed {
    logic [1:0]               cmd;
    logic [1:0]               wheel;
    logic [SPEED_W-1:0]       speed;
    logic                     exp_given;
    logic [WHEELS*DUTY_W-1:0] duty;
    logic [WHEELS-1:0]        pin_a;
    logic [WHEELS-1:0]        pin_b;
    logic [WHEELS-1:0]        changed;
  } stim_row_t;

  logic clk;
  logic rst_n;

  hwrg_in_if  in_ch ();
  hwrg_out_if out_ch ();
  hwrg_cfg_if cfg_ch ();

  hbridge_wheel_reversal_guard #(.WHEELS(WHEELS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Register shadow
  logic [MAX_W-1:0]   max_spd;
  logic [BAND_W-1:0]  band;
  logic [PAUSE_W-1:0] pause_len;
  logic [DUTY_W-1:0]  fix_duty;

  // Per-wheel shadow state
  logic signed [SPEED_W-1:0] set_speed   [WHEELS];
  logic [1:0]                wheel_dir   [WHEELS];
  logic [PAUSE_W-1:0]        pause_count [WHEELS];
  logic                      in_pause    [WHEELS];
  logic [DUTY_W-1:0]         out_duty    [WHEELS];
  logic                      out_a       [WHEELS];
  logic                      out_b       [WHEELS];

  wheel_report_t step_reps [WHEELS];
  wheel_report_t wheel_reports_due [$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches = 0;
  int reports_checked = 0;
  int cycle_count = 0;
  int n_set, n_tick, n_stop, n_unused, settings_used;

  // Directed rows, walked in order under the reset register values
  stim_row_t directed_rows [NDIR] = '{
    // outputs idle after reset, and a stop changes nothing
    '{CMD_TICK,   2'd0, 16'h0000, 1'b1, 32'h0000_0000, 4'b0000, 4'b0000, 4'b0000},
    '{CMD_STOP,   2'd0, 16'h0000, 1'b1, 32'h0000_0000, 4'b0000, 4'b0000, 4'b0000},
    '{CMD_UNUSED, 2'd3, 16'h7FFF, 1'b0, 32'h0, 4'h0, 4'h0, 4'h0},
    // full-scale clamps both ways, a speed inside the dead band, one right on its edge
    '{CMD_SET,    2'd0, 16'h7FFF, 1'b0, 32'h0, 4'h0, 4'h0, 4'h0},
    '{CMD_SET,    2'd1, 16'h8000, 1'b0, 32'h0, 4'h0, 4'h0, 4'h0},
    '{CMD_SET,    2'd2, 16'h0009, 1'b0, 32'h0, 4'h0, 4'h0, 4'h0},
    '{CMD_SET,    2'd3, 16'hFFF6, 1'b0, 32'h0, 4'h0, 4'h0, 4'h0},
    '{CMD_TICK,   2'd0, 16'h0000, 1'b1, 32'h0000_FFFF, 4'b1010, 4'b0001, 4'b1011},
    // reversal request on wheel 0, wheel 3 stops: both start a pause
    '{CMD_SET,    2'd0, 16'h8000, 1'b0, 32'h0, 4'h0, 4'h0, 4'h0},
    '{CMD_SET,    2'd3, 16'h0000, 1'b0, 32'h0, 4'h0, 4'h0, 4'h0},
    '{CMD_TICK,   2'd0, 16'h0000, 1'b0, 32'h0, 4'h0, 4'h0, 4'h0},
    '{CMD_TICK,   2'd0, 16'h0000, 1'b0, 32'h0, 4'h0, 4'h0, 4'h0},
    // same-sign requests end the pause at once
    '{CMD_SET,    2'd0, 16'h03E8, 1'b0, 32'h0, 4'h0, 4'h0, 4'h0},
    '{CMD_SET,    2'd3, 16'hFC01, 1'b0, 32'h0, 4'h0, 4'h0, 4'h0},
    '{CMD_TICK,   2'd0, 16'h0000, 1'b0, 32'h0, 4'h0, 4'h0, 4'h0},
    '{CMD_SET,    2'd1, 16'h3000, 1'b0, 32'h0, 4'h0, 4'h0, 4'h0},
    '{CMD_TICK,   2'd0, 16'h0000, 1'b0, 32'h0, 4'h0, 4'h0, 4'h0},
    '{CMD_STOP,   2'd0, 16'h0000, 1'b0, 32'h0, 4'h0, 4'h0, 4'h0},
    '{CMD_TICK,   2'd0, 16'h0000, 1'b0, 32'h0, 4'h0, 4'h0, 4'h0}
  };

  // Fixed register settings for the first six phases: max_speed, dead_band, pause_ticks, fixed_duty
  logic [CFG_DATA_W-1:0] phase_regs [6][4] = '{
    '{16'hFFFF, 16'h0000, 16'h0001, 16'h0000},
    '{16'h0001, 16'hFFFF, 16'h0001, 16'h0000},
    '{16'h0000, 16'h0005, 16'h0002, 16'hFFFF},
    '{16'h1000, 16'h0064, 16'h0003, 16'h0080},
    '{16'h4E20, 16'h0000, 16'hFFFF, 16'h0000},
    '{16'h03E8, 16'h000A, 16'h0004, 16'h0001}
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Behavioral model of the guard
  // ---------------------------------------------------------------------------

  function automatic int eff_max();
    return (max_spd == '0) ? 1 : int'(max_spd);
  endfunction

  function automatic int dir_sign(logic [1:0] d);
    case (d)
      DIR_POS: return 1;
      DIR_NEG: return -1;
      default: return 0;
    endcase
  endfunction

  function automatic logic latch_outputs(int w, logic [DUTY_W-1:0] d, logic a, logic b);
    logic chg;
    chg = (d != out_duty[w]) || (a != out_a[w]) || (b != out_b[w]);
    out_duty[w] = d;
    out_a[w]    = a;
    out_b[w]    = b;
    return chg;
  endfunction

  // One wheel's pass on a tick; returns the changed flag
  function automatic logic run_wheel(int w);
    int v;
    int mag;
    int d;
    if (in_pause[w]) begin
      if (dir_sign(wheel_dir[w]) * int'(set_speed[w]) > 0) begin
        in_pause[w] = 1'b0;
      end else begin
        if (pause_count[w] != '0) pause_count[w] = pause_count[w] - 1'b1;
        if (pause_count[w] == '0) wheel_dir[w] = DIR_NONE;
        else return 1'b0;
      end
    end
    // reversal requests are dropped
    if (dir_sign(wheel_dir[w]) * int'(set_speed[w]) < 0) set_speed[w] = '0;
    v   = int'(set_speed[w]);
    mag = (v < 0) ? -v : v;
    if (fix_duty != '0) begin
      d = (v != 0) ? int'(fix_duty) : 0;
    end else begin
      d = mag * 255 / eff_max();
      if (d > 255) d = 255;
    end
    run_wheel = latch_outputs(w, d[DUTY_W-1:0], v < 0, v > 0);
    if (v != 0) begin
      wheel_dir[w] = (v > 0) ? DIR_POS : DIR_NEG;
    end else if (wheel_dir[w] != DIR_NONE) begin
      pause_count[w] = pause_len;
      in_pause[w]    = 1'b1;
    end
  endfunction

  function automatic wheel_report_t report_of(int w, logic chg);
    wheel_report_t r;
    r.wheel_id = w[1:0];
    r.duty     = out_duty[w];
    r.pin_a    = out_a[w];
    r.pin_b    = out_b[w];
    r.changed  = chg;
    r.last     = (w == WHEELS - 1);
    return r;
  endfunction

  // Apply one command; fills step_reps and returns the number of reports
  function automatic int guard_step(logic [1:0] c, logic [1:0] w, logic signed [SPEED_W-1:0] s);
    int v;
    int m;
    case (c)
      CMD_SET: begin
        v = int'(s);
        m = eff_max();
        if (((v < 0) ? -v : v) < int'(band)) v = 0;
        if (v > m) v = m;
        if (v < -m) v = -m;
        set_speed[w] = v[SPEED_W-1:0];
        return 0;
      end
      CMD_TICK: begin
        for (int i = 0; i < WHEELS; i++) step_reps[i] = report_of(i, run_wheel(i));
        return WHEELS;
      end
      CMD_STOP: begin
        for (int i = 0; i < WHEELS; i++) begin
          set_speed[i] = '0;
          wheel_dir[i] = DIR_NONE;
          step_reps[i] = report_of(i, latch_outputs(i, '0, 1'b0, 1'b0));
        end
        return WHEELS;
      end
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic stim_row_t mk_row(logic [1:0] c, logic [1:0] w, logic [SPEED_W-1:0] s);
    stim_row_t r;
    r       = '0;
    r.cmd   = c;
    r.wheel = w;
    r.speed = s;
    return r;
  endfunction

  // Speeds aimed at zero, the rails, the dead band edge and full scale
  function automatic logic [SPEED_W-1:0] random_speed();
    int mag;
    case ($urandom_range(7))
      0: mag = 0;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: mag = int'(band) + int'($urandom_range(4)) - 2;
      4, 5: mag = eff_max() + int'($urandom_range(6)) - 3;
      default: return SPEED_W'($urandom);
    endcase
    if (mag < 0) mag = 0;
    if (mag > 32767) mag = 32767;
    if ($urandom_range(1)) mag = -mag;
    return mag[SPEED_W-1:0];
  endfunction

  function automatic stim_row_t random_row();
    int pick;
    logic [1:0] c;
    pick = $urandom_range(99);
    if (pick < 45)      c = CMD_SET;
    else if (pick < 87) c = CMD_TICK;
    else if (pick < 95) c = CMD_STOP;
    else                c = CMD_UNUSED;
    return mk_row(c, 2'($urandom_range(3)), random_speed());
  endfunction

  // Drive one command transfer and queue the reports it causes
  task automatic send_cmd(input stim_row_t row);
    int n;
    wheel_report_t rep;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= row.cmd;
    in_ch.wheel <= row.wheel;
    in_ch.speed <= row.speed;
    do @(posedge clk); while (!in_ch.ready);
    n = guard_step(row.cmd, row.wheel, row.speed);
    for (int i = 0; i < n; i++) begin
      rep = step_reps[i];
      if (row.exp_given) begin
        rep.duty    = row.duty[DUTY_W*i +: DUTY_W];
        rep.pin_a   = row.pin_a[i];
        rep.pin_b   = row.pin_b[i];
        rep.changed = row.changed[i];
      end
      wheel_reports_due.push_back(rep);
    end
    case (row.cmd)
      CMD_SET:  n_set++;
      CMD_TICK: n_tick++;
      CMD_STOP: n_stop++;
      default:  n_unused++;
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_MAX_SPEED:   max_spd   = val[MAX_W-1:0];
      CFG_DEAD_BAND:   band      = val[BAND_W-1:0];
      CFG_PAUSE_TICKS: pause_len = val[PAUSE_W-1:0];
      CFG_FIXED_DUTY:  fix_duty  = val[DUTY_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] mx, bd, pt, fd);
    write_reg(CFG_MAX_SPEED, mx);
    write_reg(CFG_DEAD_BAND, bd);
    write_reg(CFG_PAUSE_TICKS, pt);
    write_reg(CFG_FIXED_DUTY, fd);
    settings_used++;
  endtask

  // Hold off the input until every queued report is back, then let set commands finish
  task automatic drain(input int settle);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (wheel_reports_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    wheel_report_t due;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (wheel_reports_due.size() == 0) begin
        $error("wheel report with nothing pending: wheel_id %0d", out_ch.wheel_id);
        mismatches++;
      end else begin
        due = wheel_reports_due.pop_front();
        check_field("wheel_id", 16'(due.wheel_id), 16'(out_ch.wheel_id));
        check_field("duty", 16'(due.duty), 16'(out_ch.duty));
        check_field("pin_a", 16'(due.pin_a), 16'(out_ch.pin_a));
        check_field("pin_b", 16'(due.pin_b), 16'(out_ch.pin_b));
        check_field("changed", 16'(due.changed), 16'(out_ch.changed));
        check_field("last", 16'(due.last), 16'(out_ch.last));
        reports_checked++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports pending",
               cycle_count, wheel_reports_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    int k;
    stim_row_t row;

    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.cmd    = CMD_SET;
    in_ch.wheel  = 2'd0;
    in_ch.speed  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_MAX_SPEED;
    cfg_ch.data  = '0;
    n_set = 0; n_tick = 0; n_stop = 0; n_unused = 0; settings_used = 0;

    max_spd   = MAX_SPEED_RST;
    band      = DEAD_BAND_RST;
    pause_len = PAUSE_TICKS_RST;
    fix_duty  = FIXED_DUTY_RST;
    for (int i = 0; i < WHEELS; i++) begin
      set_speed[i]   = '0;
      wheel_dir[i]   = DIR_NONE;
      pause_count[i] = '0;
      in_pause[i]    = 1'b0;
      out_duty[i]    = '0;
      out_a[i]       = 1'b0;
      out_b[i]       = 1'b0;
    end

    // sender idles lightly, receiver heavily
    send_idle_pct = 20;
    recv_idle_pct = 81;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NDIR; r++) send_cmd(directed_rows[r]);

    // Lower full scale under stored speeds: scaled duty saturates, zero max acts as one
    drain(SETTLE);
    program_regs(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    send_cmd(mk_row(CMD_SET, 2'd0, 16'h7FFF));
    send_cmd(mk_row(CMD_SET, 2'd1, 16'h8000));
    send_cmd(mk_row(CMD_TICK, 2'd0, 16'h0000));
    drain(SETTLE);
    write_reg(CFG_MAX_SPEED, 16'h0000);
    send_cmd(mk_row(CMD_TICK, 2'd0, 16'h0000));

    // Random phases, each under its own register setting
    for (int ph = 0; ph < NPHASE; ph++) begin
      drain(SETTLE);
      if (ph == 3) begin
        send_idle_pct = 81;
        recv_idle_pct = 20;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph < 6) begin
        program_regs(phase_regs[ph][0], phase_regs[ph][1], phase_regs[ph][2],
                     phase_regs[ph][3]);
      end else begin
        program_regs(CFG_DATA_W'($urandom_range(32767, 1)), CFG_DATA_W'($urandom_range(60)),
                     CFG_DATA_W'($urandom_range(5)),
                     $urandom_range(1) ? CFG_DATA_W'($urandom_range(255)) : '0);
      end
      k = 0;
      while (k < ITEMS_PER_PHASE) begin
        row = random_row();
        send_cmd(row);
        if (row.cmd != CMD_UNUSED) k++;
        // one mid-phase hold-off until the result side runs dry
        if (ph == 3 && k == ITEMS_PER_PHASE / 2) drain(0);
      end
    end

    drain(SETTLE);
    $display("Sent %0d set, %0d tick, %0d stop and %0d unused commands over %0d settings",
             n_set, n_tick, n_stop, n_unused, settings_used);
    $display("Checked %0d wheel reports, %0d mismatches", reports_checked, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
